/* hw/rtl/mtt_pkg.sv */
`timescale 1ns / 1ps
// shared types, split and triangle tables for the cube triangle unit
package mtt_pkg;

	localparam int LEVEL_W        = 16;
	localparam int COORD_W        = 7;
	localparam int VERT_W         = 9;
	localparam int CELLS_PER_AXIS = 128;
	localparam int NUM_TET        = 5;
	localparam int MAX_TRI        = 10;
	localparam int CNT_W          = $clog2(MAX_TRI + 1);
	localparam int IDX_W          = $clog2(MAX_TRI);
	localparam int RANGE_W        = $clog2(CELLS_PER_AXIS + 1) + 1;

	localparam logic [LEVEL_W-1:0] THRESH_RESET = 16'd13107;

	typedef logic [2:0] corner_t;
	typedef logic [3:0] case_t;
	typedef logic [2:0][COORD_W-1:0] base_t;
	// six corner indices: vertex v is the sum of ends 2v and 2v+1
	typedef corner_t [5:0] tri_ends_t;

	typedef struct packed {
		logic [COORD_W-1:0] cube_x;
		logic [COORD_W-1:0] cube_y;
		logic [COORD_W-1:0] cube_z;
		logic [LEVEL_W-1:0] level_000;
		logic [LEVEL_W-1:0] level_001;
		logic [LEVEL_W-1:0] level_010;
		logic [LEVEL_W-1:0] level_011;
		logic [LEVEL_W-1:0] level_100;
		logic [LEVEL_W-1:0] level_101;
		logic [LEVEL_W-1:0] level_110;
		logic [LEVEL_W-1:0] level_111;
	} cube_t;

	typedef struct packed {
		logic [VERT_W-1:0] vert_a_x;
		logic [VERT_W-1:0] vert_a_y;
		logic [VERT_W-1:0] vert_a_z;
		logic [VERT_W-1:0] vert_b_x;
		logic [VERT_W-1:0] vert_b_y;
		logic [VERT_W-1:0] vert_b_z;
		logic [VERT_W-1:0] vert_c_x;
		logic [VERT_W-1:0] vert_c_y;
		logic [VERT_W-1:0] vert_c_z;
		logic              last_triangle;
	} tri_t;

	typedef struct packed {
		base_t                  base;
		logic                   par;
		case_t [NUM_TET-1:0]    cases;
	} class_t;

	typedef struct packed {
		base_t                   base;
		logic [CNT_W-1:0]        count;
		tri_ends_t [MAX_TRI-1:0] list;
	} tri_list_t;

	// corner index = x*4 + y*2 + z
	localparam corner_t SPLIT_TAB [2][NUM_TET][4] = '{
		'{'{3'd3, 3'd5, 3'd0, 3'd1}, '{3'd0, 3'd3, 3'd2, 3'd6}, '{3'd5, 3'd3, 3'd0, 3'd6},
		  '{3'd4, 3'd5, 3'd0, 3'd6}, '{3'd7, 3'd3, 3'd5, 3'd6}},
		'{'{3'd1, 3'd7, 3'd4, 3'd5}, '{3'd7, 3'd4, 3'd6, 3'd2}, '{3'd7, 3'd1, 3'd4, 3'd2},
		  '{3'd1, 3'd0, 3'd4, 3'd2}, '{3'd7, 3'd3, 3'd1, 3'd2}}
	};

	localparam logic [1:0] TRI_COUNT [16] = '{
		2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
		2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
	};

	localparam logic [1:0] TRI_EDGES [16][12] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd0, 2'd3, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3},
		'{2'd0, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2},
		'{2'd0, 2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd3},
		'{2'd0, 2'd3, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd3, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd2},
		'{2'd0, 2'd1, 2'd1, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}
	};

endpackage

/* hw/rtl/mtt_classify.sv */
`timescale 1ns / 1ps
// stages 1 and 2: corner compare, cube filter and per-tetrahedron case codes
module mtt_classify
	import mtt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  cube_t              in_cube,
	input  logic [LEVEL_W-1:0] thresh,
	output logic               in_ready,
	output logic               out_valid,
	output class_t             out_class,
	input  logic               out_ready
);

	logic               valid_s1;
	logic [7:0]         mask_s1;
	base_t              base_s1;
	logic               par_s1;
	logic               flat_s1;
	logic               valid_s2;
	class_t             class_s2;

	logic [7:0]         mask_in;
	logic               oob_in;
	logic               ready_s2;
	case_t [NUM_TET-1:0] cases_next;

	assign mask_in[0] = in_cube.level_000 > thresh;
	assign mask_in[1] = in_cube.level_001 > thresh;
	assign mask_in[2] = in_cube.level_010 > thresh;
	assign mask_in[3] = in_cube.level_011 > thresh;
	assign mask_in[4] = in_cube.level_100 > thresh;
	assign mask_in[5] = in_cube.level_101 > thresh;
	assign mask_in[6] = in_cube.level_110 > thresh;
	assign mask_in[7] = in_cube.level_111 > thresh;

	assign oob_in = (RANGE_W'(in_cube.cube_x) >= RANGE_W'(CELLS_PER_AXIS))
		|| (RANGE_W'(in_cube.cube_y) >= RANGE_W'(CELLS_PER_AXIS))
		|| (RANGE_W'(in_cube.cube_z) >= RANGE_W'(CELLS_PER_AXIS));

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_comb begin
		for (int t = 0; t < NUM_TET; t++) begin
			for (int k = 0; k < 4; k++) begin
				cases_next[t][k] = mask_s1[SPLIT_TAB[par_s1][t][k]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1 && !flat_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mask_s1 <= mask_in;
			base_s1 <= {in_cube.cube_z, in_cube.cube_y, in_cube.cube_x};
			par_s1  <= in_cube.cube_x[0] ^ in_cube.cube_y[0] ^ in_cube.cube_z[0];
			flat_s1 <= oob_in || (mask_in == 8'h00) || (mask_in == 8'hFF);
		end
		if (ready_s2 && valid_s1) begin
			class_s2.base  <= base_s1;
			class_s2.par   <= par_s1;
			class_s2.cases <= cases_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_class = class_s2;

endmodule

/* hw/rtl/mtt_compact.sv */
`timescale 1ns / 1ps
// stage 3: packs the triangles of all five tetrahedra into one ordered list
module mtt_compact
	import mtt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  class_t    in_class,
	output logic      in_ready,
	output logic      out_valid,
	output tri_list_t out_list,
	input  logic      out_ready
);

	logic                    valid_s3;
	tri_list_t               list_s3;

	logic [1:0]              cnt   [NUM_TET];
	logic [CNT_W-1:0]        off   [NUM_TET];
	logic [CNT_W-1:0]        total;
	tri_ends_t               ents  [NUM_TET][2];
	tri_ends_t [MAX_TRI-1:0] list_next;

	always_comb begin
		total = '0;
		for (int t = 0; t < NUM_TET; t++) begin
			cnt[t] = TRI_COUNT[in_class.cases[t]];
			off[t] = total;
			total  = total + CNT_W'(cnt[t]);
			for (int k = 0; k < 2; k++) begin
				for (int e = 0; e < 6; e++) begin
					ents[t][k][e] =
						SPLIT_TAB[in_class.par][t][TRI_EDGES[in_class.cases[t]][k * 6 + e]];
				end
			end
		end
		for (int j = 0; j < MAX_TRI; j++) begin
			list_next[j] = '0;
			for (int t = 0; t < NUM_TET; t++) begin
				for (int k = 0; k < 2; k++) begin
					if ((2'(k) < cnt[t]) && (off[t] + CNT_W'(k) == CNT_W'(j))) begin
						list_next[j] = ents[t][k];
					end
				end
			end
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid && (total != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			list_s3.base  <= in_class.base;
			list_s3.count <= total;
			list_s3.list  <= list_next;
		end
	end

	assign out_valid = valid_s3;
	assign out_list  = list_s3;

endmodule

/* hw/rtl/mtt_emit.sv */
`timescale 1ns / 1ps
// stages 4 and 5: steps through the triangle list, one vertex triple per cycle
module mtt_emit
	import mtt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  tri_list_t in_list,
	output logic      in_ready,
	output logic      result_valid,
	output tri_t      result
);

	logic                    valid_s4;
	tri_list_t               list_s4;
	logic [IDX_W-1:0]        idx_q;
	logic                    valid_s5;
	tri_t                    tri_s5;

	logic                    last_now;
	tri_ends_t               sel;
	logic [2:0][2:0][VERT_W-1:0] vtx;
	tri_t                    tri_next;

	assign last_now = CNT_W'(idx_q) == list_s4.count - CNT_W'(1);
	assign in_ready = !valid_s4 || last_now;
	assign sel      = list_s4.list[idx_q];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			for (int ax = 0; ax < 3; ax++) begin
				vtx[v][ax] = {1'b0, list_s4.base[ax], 1'b0}
					+ VERT_W'(sel[2 * v][2 - ax])
					+ VERT_W'(sel[2 * v + 1][2 - ax]);
			end
		end
		tri_next.vert_a_x      = vtx[0][0];
		tri_next.vert_a_y      = vtx[0][1];
		tri_next.vert_a_z      = vtx[0][2];
		tri_next.vert_b_x      = vtx[1][0];
		tri_next.vert_b_y      = vtx[1][1];
		tri_next.vert_b_z      = vtx[1][2];
		tri_next.vert_c_x      = vtx[2][0];
		tri_next.vert_c_y      = vtx[2][1];
		tri_next.vert_c_z      = vtx[2][2];
		tri_next.last_triangle = last_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			idx_q    <= '0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
			if (in_ready) begin
				valid_s4 <= in_valid;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			list_s4 <= in_list;
		end
		if (valid_s4) begin
			tri_s5 <= tri_next;
		end
	end

	assign result_valid = valid_s5;
	assign result       = tri_s5;

endmodule

/* hw/rtl/marching_tetrahedra_cell_triangles_unit.sv */
`timescale 1ns / 1ps
// top level of the cube triangle unit: threshold register and pipeline
// A cube is taken at a clock edge with start high and busy low. Its triangles
// then appear on result for one cycle each with result_valid high, in
// tetrahedron order, with last_triangle high on the final one. When the list
// stepper is free, a cube passes the stage 1 to 5 registers in turn before
// its first triangle shows. The stepper puts out one triangle per cycle and
// takes the next list only with the last triangle of the current one; a cube
// has up to ten triangles. A cube that is uniform or out of range is dropped
// before the stepper and gives nothing. The receiver cannot stall, so results
// must be taken when shown. The threshold is written with cfg_we; the user
// must write it only while no cube is in flight; the block does not check.
module marching_tetrahedra_cell_triangles_unit
	import mtt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cube_t              cube,
	input  logic               cfg_we,
	input  logic [LEVEL_W-1:0] cfg_wdata,
	output logic               result_valid,
	output tri_t               result
);

	logic [LEVEL_W-1:0] thresh_q;
	logic               cls_ready;
	logic               cls_valid;
	class_t             cls_data;
	logic               cmp_ready;
	logic               cmp_valid;
	tri_list_t          cmp_list;
	logic               emt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	assign busy = !cls_ready;

	mtt_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_cube   (cube),
		.thresh    (thresh_q),
		.in_ready  (cls_ready),
		.out_valid (cls_valid),
		.out_class (cls_data),
		.out_ready (cmp_ready)
	);

	mtt_compact u_compact (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_valid),
		.in_class  (cls_data),
		.in_ready  (cmp_ready),
		.out_valid (cmp_valid),
		.out_list  (cmp_list),
		.out_ready (emt_ready)
	);

	mtt_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cmp_valid),
		.in_list      (cmp_list),
		.in_ready     (emt_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
